[src/kpts_pkg.sv]
// Shared types and constants of the keyed position trail store.
// No dependencies; the front end, back end, top and testbench import this package.
`default_nettype none
package kpts_pkg;

  // Sizing
  localparam int ENTRIES = 40;
  localparam int POINTS  = 32;
  localparam int SLOT_W  = $clog2(ENTRIES);
  localparam int PT_W    = $clog2(POINTS);
  localparam int CNT_W   = $clog2(POINTS + 1);
  localparam int PA_W    = $clog2(ENTRIES * POINTS);
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // Field widths
  localparam int REQ_W  = 2;
  localparam int KEY_W  = 24;
  localparam int LAT_W  = 31;
  localparam int LON_W  = 32;
  localparam int TIME_W = 32;
  localparam int PIDX_W = 5;
  localparam int STEP_W = 16;
  localparam int STAT_W = 2;
  localparam int OCNT_W = 6;
  localparam int CMP_W  = (CNT_W > PIDX_W) ? CNT_W : PIDX_W;
  localparam int IDX_W  = CMP_W + 2;

  localparam logic [STEP_W-1:0] MIN_STEP_RST = 16'd2703;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_APPEND = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] ST_DONE   = 2'd0;
  localparam logic [STAT_W-1:0] ST_SKIP   = 2'd1;
  localparam logic [STAT_W-1:0] ST_ABSENT = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE  = 2'd3;

  typedef enum logic [1:0] {OP_APPEND, OP_READ, OP_CLEAR, OP_NONE} op_t;

  typedef struct packed {
    op_t                       op;
    logic [KEY_W-1:0]          key;
    logic signed [LAT_W-1:0]   lat;
    logic signed [LON_W-1:0]   lon;
    logic [TIME_W-1:0]         now;
    logic [PIDX_W-1:0]         pidx;
  } cmd_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] last;
    logic [PT_W-1:0]   head;
    logic [CNT_W-1:0]  cnt;
  } slot_t;

  typedef enum logic [3:0] {
    B_IDLE, B_SCAN, B_DECIDE, B_RDOUT, B_DIFF, B_MUL, B_CMP, B_WRITE
  } bst_t;

endpackage
`default_nettype wire

[src/kpts_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module kpts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[src/kpts_front.sv]
// Front end: takes requests, classifies the request code, queues commands.
// Depends on kpts_pkg.
`default_nettype none
module kpts_front (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [kpts_pkg::REQ_W-1:0]        in_req_type,
  input  wire logic [kpts_pkg::KEY_W-1:0]        in_aircraft_id,
  input  wire logic signed [kpts_pkg::LAT_W-1:0] in_lat_in,
  input  wire logic signed [kpts_pkg::LON_W-1:0] in_lon_in,
  input  wire logic [kpts_pkg::TIME_W-1:0]       in_now_ms,
  input  wire logic [kpts_pkg::PIDX_W-1:0]       in_point_index,
  output logic                                   cmd_vld,
  output kpts_pkg::cmd_t                         cmd,
  input  wire logic                              cmd_pop
);
  import kpts_pkg::*;

  cmd_t              q_r [QDEPTH];
  logic [QPTR_W-1:0] wptr_r, wptr_nxt;
  logic [QPTR_W-1:0] rptr_r, rptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  cmd_t              in_cmd;
  logic              push;
  logic              pop;

  // Classify the request code
  always_comb begin
    in_cmd      = '0;
    in_cmd.key  = in_aircraft_id;
    in_cmd.lat  = in_lat_in;
    in_cmd.lon  = in_lon_in;
    in_cmd.now  = in_now_ms;
    in_cmd.pidx = in_point_index;
    case (in_req_type)
      REQ_APPEND: in_cmd.op = OP_APPEND;
      REQ_READ:   in_cmd.op = OP_READ;
      REQ_CLEAR:  in_cmd.op = OP_CLEAR;
      default:    in_cmd.op = OP_NONE;
    endcase
  end

  assign busy    = (cnt_r == QCNT_W'(QDEPTH));
  assign push    = start && !busy;
  assign cmd_vld = (cnt_r != '0);
  assign pop     = cmd_pop && cmd_vld;
  assign cmd     = q_r[rptr_r];

  // Advance queue pointers
  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = (wptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (pop) begin
      rptr_nxt = (rptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Store the incoming beat
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wptr_r] <= in_cmd;
    end
  end

endmodule
`default_nettype wire

[src/kpts_back.sv]
// Back end: slot search, recency choice, trail ring access and result.
// Depends on kpts_pkg and kpts_ram.
`default_nettype none
module kpts_back (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cmd_vld,
  input  wire kpts_pkg::cmd_t               cmd,
  output logic                              cmd_pop,
  input  wire logic [kpts_pkg::STEP_W-1:0]  min_step,
  output logic                              out_strobe,
  output logic [kpts_pkg::STAT_W-1:0]       out_status,
  output logic [kpts_pkg::OCNT_W-1:0]       out_point_count,
  output logic signed [kpts_pkg::LAT_W-1:0] out_lat_out,
  output logic signed [kpts_pkg::LON_W-1:0] out_lon_out
);
  import kpts_pkg::*;

  localparam int PW = LAT_W + LON_W;

  bst_t               state_r, state_nxt;
  cmd_t               cmd_r, cmd_nxt;
  logic [SLOT_W-1:0]  scan_idx_r, scan_idx_nxt;
  logic               issue_done_r, issue_done_nxt;
  logic               chk_vld_r, chk_vld_nxt;
  logic [SLOT_W-1:0]  chk_idx_r, chk_idx_nxt;
  logic               found_r, found_nxt;
  logic [SLOT_W-1:0]  hit_idx_r, hit_idx_nxt;
  slot_t              hit_word_r, hit_word_nxt;
  logic               free_r, free_nxt;
  logic [SLOT_W-1:0]  free_idx_r, free_idx_nxt;
  logic               lru_vld_r, lru_vld_nxt;
  logic [SLOT_W-1:0]  lru_idx_r, lru_idx_nxt;
  logic [TIME_W-1:0]  lru_last_r, lru_last_nxt;
  logic [SLOT_W-1:0]  sel_r, sel_nxt;
  logic [PT_W-1:0]    head_r, head_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [STEP_W-1:0]  dx_r, dx_nxt, dy_r, dy_nxt;
  logic               lt_r, lt_nxt;
  logic [2*STEP_W-1:0] dx2_r, dy2_r, ms2_r;
  logic [ENTRIES-1:0] used_r, used_nxt;
  logic               ostb_r, ostb_nxt;
  logic [STAT_W-1:0]  ostat_r, ostat_nxt;
  logic [OCNT_W-1:0]  ocnt_r, ocnt_nxt;
  logic signed [LAT_W-1:0] olat_r, olat_nxt;
  logic signed [LON_W-1:0] olon_r, olon_nxt;

  // Memory ports
  logic              s_we;
  logic [SLOT_W-1:0] s_waddr, s_raddr;
  slot_t             s_wdata, s_rdata;
  logic              p_we;
  logic [PA_W-1:0]   p_waddr, p_raddr;
  logic [PW-1:0]     p_wdata, p_rdata;

  // Datapath helpers
  logic [SLOT_W-1:0]       d_sel;
  logic [PT_W-1:0]         d_head;
  logic [CNT_W-1:0]        d_cnt;
  logic [PT_W-1:0]         last_pt;
  logic [IDX_W-1:0]        rd_sum;
  logic [PT_W-1:0]         rd_pt;
  logic signed [LAT_W-1:0] p_lat;
  logic signed [LON_W-1:0] p_lon;
  logic signed [LON_W:0]   dlon;
  logic signed [LAT_W:0]   dlat;
  logic [LON_W:0]          adx;
  logic [LAT_W:0]          ady;
  logic                    close;
  logic [PT_W-1:0]         head_inc;
  logic [CNT_W-1:0]        cnt_inc;

  kpts_ram #(.WIDTH($bits(slot_t)), .DEPTH(ENTRIES)) u_slot_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  kpts_ram #(.WIDTH(PW), .DEPTH(ENTRIES * POINTS)) u_point_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  // Slot choice: hit, else first free, else least recently seen
  always_comb begin
    if (found_r) begin
      d_sel  = hit_idx_r;
      d_head = hit_word_r.head;
      d_cnt  = hit_word_r.cnt;
    end else begin
      d_sel  = free_r ? free_idx_r : lru_idx_r;
      d_head = '0;
      d_cnt  = '0;
    end
  end

  // Ring positions of the newest point and of the requested point
  assign last_pt = (d_head == '0) ? PT_W'(POINTS - 1) : d_head - 1'b1;
  assign rd_sum  = IDX_W'(d_head) + IDX_W'(POINTS) - IDX_W'(d_cnt) + IDX_W'(cmd_r.pidx);
  assign rd_pt   = (rd_sum >= IDX_W'(POINTS)) ? PT_W'(rd_sum - IDX_W'(POINTS))
                                              : PT_W'(rd_sum);

  // Distance to the newest stored point
  assign p_lat = p_rdata[PW-1:LON_W];
  assign p_lon = p_rdata[LON_W-1:0];
  assign dlon  = {cmd_r.lon[LON_W-1], cmd_r.lon} - {p_lon[LON_W-1], p_lon};
  assign dlat  = {cmd_r.lat[LAT_W-1], cmd_r.lat} - {p_lat[LAT_W-1], p_lat};
  assign adx   = dlon[LON_W] ? (LON_W+1)'(-dlon) : (LON_W+1)'(dlon);
  assign ady   = dlat[LAT_W] ? (LAT_W+1)'(-dlat) : (LAT_W+1)'(dlat);
  assign close = lt_r && ((2*STEP_W+1)'(dx2_r) + (2*STEP_W+1)'(dy2_r)
                          < (2*STEP_W+1)'(ms2_r));

  assign head_inc = (head_r == PT_W'(POINTS - 1)) ? '0 : head_r + 1'b1;
  assign cnt_inc  = (cnt_r == CNT_W'(POINTS)) ? cnt_r : cnt_r + 1'b1;

  assign s_raddr = scan_idx_r;
  assign p_waddr = PA_W'(PA_W'(sel_r) * PA_W'(POINTS) + PA_W'(head_r));
  assign p_wdata = {cmd_r.lat, cmd_r.lon};

  // Sequencer: next state, memory strobes, result
  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    scan_idx_nxt   = scan_idx_r;
    issue_done_nxt = issue_done_r;
    chk_vld_nxt    = 1'b0;
    chk_idx_nxt    = scan_idx_r;
    found_nxt      = found_r;
    hit_idx_nxt    = hit_idx_r;
    hit_word_nxt   = hit_word_r;
    free_nxt       = free_r;
    free_idx_nxt   = free_idx_r;
    lru_vld_nxt    = lru_vld_r;
    lru_idx_nxt    = lru_idx_r;
    lru_last_nxt   = lru_last_r;
    sel_nxt        = sel_r;
    head_nxt       = head_r;
    cnt_nxt        = cnt_r;
    dx_nxt         = dx_r;
    dy_nxt         = dy_r;
    lt_nxt         = lt_r;
    used_nxt       = used_r;
    ostb_nxt       = 1'b0;
    ostat_nxt      = ostat_r;
    ocnt_nxt       = ocnt_r;
    olat_nxt       = olat_r;
    olon_nxt       = olon_r;
    cmd_pop        = 1'b0;
    s_we           = 1'b0;
    s_waddr        = sel_r;
    s_wdata        = {cmd_r.key, cmd_r.now, head_r, cnt_r};
    p_we           = 1'b0;
    p_raddr        = PA_W'(PA_W'(d_sel) * PA_W'(POINTS) + PA_W'(last_pt));

    case (state_r)
      B_IDLE: begin
        if (cmd_vld) begin
          cmd_pop        = 1'b1;
          cmd_nxt        = cmd;
          scan_idx_nxt   = '0;
          issue_done_nxt = 1'b0;
          found_nxt      = 1'b0;
          free_nxt       = 1'b0;
          lru_vld_nxt    = 1'b0;
          case (cmd.op)
            OP_APPEND, OP_READ: begin
              state_nxt = B_SCAN;
            end
            OP_CLEAR: begin
              used_nxt  = '0;
              ostb_nxt  = 1'b1;
              ostat_nxt = ST_DONE;
              ocnt_nxt  = '0;
              olat_nxt  = '0;
              olon_nxt  = '0;
            end
            default: begin
              ostb_nxt  = 1'b1;
              ostat_nxt = ST_ABSENT;
              ocnt_nxt  = '0;
              olat_nxt  = '0;
              olon_nxt  = '0;
            end
          endcase
        end
      end

      B_SCAN: begin
        // Issue one slot read per cycle
        if (!issue_done_r) begin
          chk_vld_nxt = 1'b1;
          if (scan_idx_r == SLOT_W'(ENTRIES - 1)) begin
            issue_done_nxt = 1'b1;
          end else begin
            scan_idx_nxt = scan_idx_r + 1'b1;
          end
        end
        // Check the slot read last cycle
        if (chk_vld_r) begin
          if (used_r[chk_idx_r]) begin
            if (!found_r && s_rdata.key == cmd_r.key) begin
              found_nxt    = 1'b1;
              hit_idx_nxt  = chk_idx_r;
              hit_word_nxt = s_rdata;
            end
            if (!lru_vld_r || s_rdata.last < lru_last_r) begin
              lru_vld_nxt  = 1'b1;
              lru_idx_nxt  = chk_idx_r;
              lru_last_nxt = s_rdata.last;
            end
          end else if (!free_r) begin
            free_nxt     = 1'b1;
            free_idx_nxt = chk_idx_r;
          end
          if (chk_idx_r == SLOT_W'(ENTRIES - 1)) begin
            state_nxt = B_DECIDE;
          end
        end
      end

      B_DECIDE: begin
        sel_nxt  = d_sel;
        head_nxt = d_head;
        cnt_nxt  = d_cnt;
        if (cmd_r.op == OP_READ) begin
          p_raddr = PA_W'(PA_W'(d_sel) * PA_W'(POINTS) + PA_W'(rd_pt));
          olat_nxt = '0;
          olon_nxt = '0;
          if (!found_r || d_cnt == '0) begin
            ostb_nxt  = 1'b1;
            ostat_nxt = ST_ABSENT;
            ocnt_nxt  = '0;
            state_nxt = B_IDLE;
          end else if (CMP_W'(cmd_r.pidx) >= CMP_W'(d_cnt)) begin
            ostb_nxt  = 1'b1;
            ostat_nxt = ST_RANGE;
            ocnt_nxt  = OCNT_W'(d_cnt);
            state_nxt = B_IDLE;
          end else begin
            state_nxt = B_RDOUT;
          end
        end else begin
          state_nxt = (d_cnt == '0) ? B_WRITE : B_DIFF;
        end
      end

      B_RDOUT: begin
        ostb_nxt  = 1'b1;
        ostat_nxt = ST_DONE;
        ocnt_nxt  = OCNT_W'(cnt_r);
        olat_nxt  = p_lat;
        olon_nxt  = p_lon;
        state_nxt = B_IDLE;
      end

      B_DIFF: begin
        lt_nxt    = (adx < (LON_W+1)'(min_step)) && (ady < (LAT_W+1)'(min_step));
        dx_nxt    = STEP_W'(adx);
        dy_nxt    = STEP_W'(ady);
        state_nxt = B_MUL;
      end

      B_MUL: begin
        state_nxt = B_CMP;
      end

      B_CMP: begin
        if (close) begin
          // Refresh recency only
          s_we      = 1'b1;
          ostb_nxt  = 1'b1;
          ostat_nxt = ST_SKIP;
          ocnt_nxt  = OCNT_W'(cnt_r);
          olat_nxt  = '0;
          olon_nxt  = '0;
          state_nxt = B_IDLE;
        end else begin
          state_nxt = B_WRITE;
        end
      end

      B_WRITE: begin
        p_we             = 1'b1;
        s_we             = 1'b1;
        s_wdata          = {cmd_r.key, cmd_r.now, head_inc, cnt_inc};
        used_nxt[sel_r]  = 1'b1;
        ostb_nxt         = 1'b1;
        ostat_nxt        = ST_DONE;
        ocnt_nxt         = OCNT_W'(cnt_inc);
        olat_nxt         = '0;
        olon_nxt         = '0;
        state_nxt        = B_IDLE;
      end

      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= B_IDLE;
      used_r       <= '0;
      ostb_r       <= 1'b0;
      chk_vld_r    <= 1'b0;
      issue_done_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      used_r       <= used_nxt;
      ostb_r       <= ostb_nxt;
      chk_vld_r    <= chk_vld_nxt;
      issue_done_r <= issue_done_nxt;
    end
  end

  // Payload and working registers
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    scan_idx_r <= scan_idx_nxt;
    chk_idx_r  <= chk_idx_nxt;
    found_r    <= found_nxt;
    hit_idx_r  <= hit_idx_nxt;
    hit_word_r <= hit_word_nxt;
    free_r     <= free_nxt;
    free_idx_r <= free_idx_nxt;
    lru_vld_r  <= lru_vld_nxt;
    lru_idx_r  <= lru_idx_nxt;
    lru_last_r <= lru_last_nxt;
    sel_r      <= sel_nxt;
    head_r     <= head_nxt;
    cnt_r      <= cnt_nxt;
    dx_r       <= dx_nxt;
    dy_r       <= dy_nxt;
    lt_r       <= lt_nxt;
    dx2_r      <= dx_r * dx_r;
    dy2_r      <= dy_r * dy_r;
    ms2_r      <= min_step * min_step;
    ostat_r    <= ostat_nxt;
    ocnt_r     <= ocnt_nxt;
    olat_r     <= olat_nxt;
    olon_r     <= olon_nxt;
  end

  assign out_strobe      = ostb_r;
  assign out_status      = ostat_r;
  assign out_point_count = ocnt_r;
  assign out_lat_out     = olat_r;
  assign out_lon_out     = olon_r;

endmodule
`default_nettype wire

[src/keyed_position_trail_store_unit.sv]
// Keyed position trail store. Appends and reads search the slots; clear and
// unknown codes give their result without a search. Requests are handled one
// at a time; the rate is set by the slot search, which reads one slot word per
// cycle, and a 2-deep queue takes requests meanwhile. Results last one cycle
// and cannot be stalled. Reset frees all slots; min_step is 2703.
`default_nettype none
module keyed_position_trail_store_unit (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [kpts_pkg::REQ_W-1:0]        in_req_type,
  input  wire logic [kpts_pkg::KEY_W-1:0]        in_aircraft_id,
  input  wire logic signed [kpts_pkg::LAT_W-1:0] in_lat_in,
  input  wire logic signed [kpts_pkg::LON_W-1:0] in_lon_in,
  input  wire logic [kpts_pkg::TIME_W-1:0]       in_now_ms,
  input  wire logic [kpts_pkg::PIDX_W-1:0]       in_point_index,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [kpts_pkg::STEP_W-1:0]       cfg_min_step,
  output logic                                   out_strobe,
  output logic [kpts_pkg::STAT_W-1:0]            out_status,
  output logic [kpts_pkg::OCNT_W-1:0]            out_point_count,
  output logic signed [kpts_pkg::LAT_W-1:0]      out_lat_out,
  output logic signed [kpts_pkg::LON_W-1:0]      out_lon_out
);
  import kpts_pkg::*;

  logic [STEP_W-1:0] step_r, step_nxt;
  logic              cmd_vld;
  logic              cmd_pop;
  cmd_t              cmd;

  // Configuration register
  assign cfg_ready = 1'b1;
  assign step_nxt  = (cfg_valid && cfg_ready) ? cfg_min_step : step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= MIN_STEP_RST;
    end else begin
      step_r <= step_nxt;
    end
  end

  kpts_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_req_type    (in_req_type),
    .in_aircraft_id (in_aircraft_id),
    .in_lat_in      (in_lat_in),
    .in_lon_in      (in_lon_in),
    .in_now_ms      (in_now_ms),
    .in_point_index (in_point_index),
    .cmd_vld        (cmd_vld),
    .cmd            (cmd),
    .cmd_pop        (cmd_pop)
  );

  kpts_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_vld         (cmd_vld),
    .cmd             (cmd),
    .cmd_pop         (cmd_pop),
    .min_step        (step_r),
    .out_strobe      (out_strobe),
    .out_status      (out_status),
    .out_point_count (out_point_count),
    .out_lat_out     (out_lat_out),
    .out_lon_out     (out_lon_out)
  );

endmodule
`default_nettype wire

[dv/tb_keyed_position_trail_store_unit.sv]
// Testbench for the keyed position trail store: random and directed requests,
// a behavioral predictor of slots and rings, and a field-by-field result check.
// Depends on kpts_pkg and keyed_position_trail_store_unit.
`timescale 1ns / 100ps
module tb_keyed_position_trail_store_unit;
  import kpts_pkg::*;

  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic [OCNT_W-1:0]       count;
    logic signed [LAT_W-1:0] lat;
    logic signed [LON_W-1:0] lon;
  } trail_resp_t;

  typedef struct {
    logic [REQ_W-1:0]        req;
    logic [KEY_W-1:0]        key;
    logic signed [LAT_W-1:0] lat;
    logic signed [LON_W-1:0] lon;
    logic [TIME_W-1:0]       now;
    logic [PIDX_W-1:0]       pidx;
    bit                      is_cfg;
    logic [STEP_W-1:0]       step;
  } trail_req_t;

  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 3 * ENTRIES + 20;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [REQ_W-1:0] in_req_type = '0;
  logic [KEY_W-1:0] in_aircraft_id = '0;
  logic signed [LAT_W-1:0] in_lat_in = '0;
  logic signed [LON_W-1:0] in_lon_in = '0;
  logic [TIME_W-1:0] in_now_ms = '0;
  logic [PIDX_W-1:0] in_point_index = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [STEP_W-1:0] cfg_min_step = '0;
  logic out_strobe;
  logic [STAT_W-1:0] out_status;
  logic [OCNT_W-1:0] out_point_count;
  logic signed [LAT_W-1:0] out_lat_out;
  logic signed [LON_W-1:0] out_lon_out;

  keyed_position_trail_store_unit u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req_type(in_req_type), .in_aircraft_id(in_aircraft_id),
    .in_lat_in(in_lat_in), .in_lon_in(in_lon_in), .in_now_ms(in_now_ms),
    .in_point_index(in_point_index), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_min_step(cfg_min_step), .out_strobe(out_strobe), .out_status(out_status),
    .out_point_count(out_point_count), .out_lat_out(out_lat_out),
    .out_lon_out(out_lon_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state
  logic [STEP_W-1:0] pred_step;
  logic [KEY_W-1:0] pred_key [ENTRIES];
  bit pred_used [ENTRIES];
  logic [TIME_W-1:0] pred_seen [ENTRIES];
  int pred_head [ENTRIES];
  int pred_cnt [ENTRIES];
  logic signed [LAT_W-1:0] pred_lat [ENTRIES][POINTS];
  logic signed [LON_W-1:0] pred_lon [ENTRIES][POINTS];

  trail_req_t pending_q[$];
  trail_resp_t expected_q[$];
  int errors = 0;
  int idle_cycles = 0;
  bit stim_done = 1'b0;
  bit cfg_wait = 1'b0;
  int beat_no = 0;

  function automatic int find_trail(logic [KEY_W-1:0] key);
    for (int i = 0; i < ENTRIES; i++)
      if (pred_used[i] && pred_key[i] == key) return i;
    return -1;
  endfunction

  function automatic trail_resp_t predict_trail(trail_req_t r);
    trail_resp_t o;
    int s, last, idx;
    longint dx, dy, ms;
    o = '{status: ST_ABSENT, count: '0, lat: '0, lon: '0};
    if (r.req == REQ_APPEND) begin
      s = find_trail(r.key);
      if (s < 0) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (!pred_used[i]) begin
            s = i;
            break;
          end
          if (s < 0 || pred_seen[i] < pred_seen[s]) s = i;
        end
        pred_used[s] = 1'b1;
        pred_key[s] = r.key;
        pred_cnt[s] = 0;
        pred_head[s] = 0;
      end
      if (pred_cnt[s] > 0) begin
        last = (pred_head[s] + POINTS - 1) % POINTS;
        dx = longint'(r.lon) - longint'(pred_lon[s][last]);
        dy = longint'(r.lat) - longint'(pred_lat[s][last]);
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        ms = longint'(pred_step);
        if (dx < ms && dy < ms && dx * dx + dy * dy < ms * ms) begin
          pred_seen[s] = r.now;
          o.status = ST_SKIP;
          o.count = OCNT_W'(pred_cnt[s]);
          return o;
        end
      end
      pred_lat[s][pred_head[s]] = r.lat;
      pred_lon[s][pred_head[s]] = r.lon;
      pred_head[s] = (pred_head[s] + 1) % POINTS;
      if (pred_cnt[s] < POINTS) pred_cnt[s]++;
      pred_seen[s] = r.now;
      o.status = ST_DONE;
      o.count = OCNT_W'(pred_cnt[s]);
    end else if (r.req == REQ_READ) begin
      s = find_trail(r.key);
      if (s >= 0 && pred_cnt[s] > 0) begin
        o.count = OCNT_W'(pred_cnt[s]);
        if (r.pidx >= pred_cnt[s]) begin
          o.status = ST_RANGE;
        end else begin
          idx = (pred_head[s] + 2 * POINTS - pred_cnt[s] + r.pidx) % POINTS;
          o.lat = pred_lat[s][idx];
          o.lon = pred_lon[s][idx];
          o.status = ST_DONE;
        end
      end
    end else if (r.req == REQ_CLEAR) begin
      for (int i = 0; i < ENTRIES; i++) pred_used[i] = 1'b0;
      o.status = ST_DONE;
    end
    return o;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("ERROR %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // Stimulus helpers
  function automatic trail_req_t mk_req(logic [REQ_W-1:0] req, logic [KEY_W-1:0] key,
                                        longint lat, longint lon,
                                        logic [TIME_W-1:0] now, int pidx);
    trail_req_t r;
    r.req = req; r.key = key; r.lat = LAT_W'(lat); r.lon = LON_W'(lon); r.now = now;
    r.pidx = PIDX_W'(pidx); r.is_cfg = 1'b0; r.step = '0;
    return r;
  endfunction

  function automatic trail_req_t mk_cfg(logic [STEP_W-1:0] step);
    trail_req_t r;
    r = mk_req(REQ_APPEND, '0, 0, 0, '0, 0);
    r.is_cfg = 1'b1;
    r.step = step;
    return r;
  endfunction

  // Fill the pending queue: directed part, then random phases with config changes
  initial begin
    logic [KEY_W-1:0] keys [48];
    longint blat, blon, slat, slon;
    logic [TIME_W-1:0] clock_ms;
    int k, j;
    pending_q.push_back(mk_req(REQ_READ, 24'h000001, 0, 0, 0, 0));
    pending_q.push_back(mk_req(REQ_APPEND, 24'hFFFFFF, 900000000, 1800000000, 32'hFFFFFFFF, 31));
    pending_q.push_back(mk_req(REQ_APPEND, 24'hFFFFFF, 900000100, 1800000100, 5, 0));
    pending_q.push_back(mk_req(REQ_APPEND, 24'hFFFFFF, -900000000, -1800000000, 6, 0));
    pending_q.push_back(mk_req(REQ_APPEND, 24'h000000, -1073741824, -2147483648, 0, 0));
    pending_q.push_back(mk_req(REQ_APPEND, 24'h000000, 1073741823, 2147483647, 1, 0));
    pending_q.push_back(mk_req(REQ_APPEND, 24'h000000, 1073741823, 2147483647 - 2702, 2, 0));
    pending_q.push_back(mk_req(REQ_APPEND, 24'h000000, 1073741823 - 1911, 2147483647 - 1911, 3, 0));
    pending_q.push_back(mk_req(REQ_READ, 24'hFFFFFF, 0, 0, 0, 0));
    pending_q.push_back(mk_req(REQ_READ, 24'hFFFFFF, 0, 0, 0, 1));
    pending_q.push_back(mk_req(REQ_READ, 24'hFFFFFF, 0, 0, 0, 2));
    pending_q.push_back(mk_req(REQ_READ, 24'h000000, 0, 0, 0, 31));
    pending_q.push_back(mk_req(REQ_READ, 24'h123456, 0, 0, 0, 0));
    pending_q.push_back(mk_req(REQ_UNUSED, 24'hFFFFFF, 0, 0, 0, 0));
    pending_q.push_back(mk_req(REQ_CLEAR, 0, 0, 0, 0, 0));
    pending_q.push_back(mk_req(REQ_READ, 24'hFFFFFF, 0, 0, 0, 0));
    pending_q.push_back(mk_cfg(16'd0));
    // Min step zero: identical fix is still stored; fill a ring past POINTS
    for (int i = 0; i < POINTS + 3; i++)
      pending_q.push_back(mk_req(REQ_APPEND, 24'h00ABCD, 100, -100, i, 0));
    for (int i = 0; i < 32; i += 5)
      pending_q.push_back(mk_req(REQ_READ, 24'h00ABCD, 0, 0, 0, i));
    pending_q.push_back(mk_cfg(16'hFFFF));
    pending_q.push_back(mk_req(REQ_APPEND, 24'h00ABCD, 100 + 65535, -100, 50, 0));
    pending_q.push_back(mk_req(REQ_APPEND, 24'h00ABCD, 100 + 65535 + 46340, -100 + 46340, 51, 0));
    pending_q.push_back(mk_req(REQ_READ, 24'h00ABCD, 0, 0, 0, 31));

    // Random phases
    clock_ms = 100;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: pending_q.push_back(mk_cfg(16'd2703));
        1: pending_q.push_back(mk_cfg(16'd1));
        2: pending_q.push_back(mk_cfg($urandom_range(65535, 0)));
        3: pending_q.push_back(mk_cfg(16'hFFFF));
        4: pending_q.push_back(mk_cfg(16'd0));
        default: pending_q.push_back(mk_cfg(16'd500));
      endcase
      // 48 keys over 40 slots forces eviction
      for (int i = 0; i < 48; i++) keys[i] = (i < 8) ? $urandom_range(47, 0) : $urandom;
      for (int n = 0; n < 180; n++) begin
        k = $urandom_range(47, 0);
        clock_ms = ($urandom_range(19, 0) == 0) ? $urandom : clock_ms + $urandom_range(50, 0);
        j = $urandom_range(99, 0);
        blat = $urandom_range(2000000, 0) - 1000000 + k * 1000;
        blon = $urandom_range(2000000, 0) - 1000000;
        if (j < 55) begin
          slat = (j < 20) ? k * 1000 + $urandom_range(6000, 0) - 3000 : blat;
          slon = (j < 20) ? $urandom_range(6000, 0) - 3000 : blon;
          pending_q.push_back(mk_req(REQ_APPEND, keys[k], slat, slon, clock_ms, $urandom));
        end else if (j < 90) begin
          pending_q.push_back(mk_req(REQ_READ, ($urandom_range(9, 0) == 0) ? $urandom : keys[k],
                                     $urandom, $urandom, $urandom, $urandom));
        end else if (j < 97) begin
          pending_q.push_back(mk_req(REQ_APPEND, $urandom, $signed(31'($urandom)),
                                     $signed($urandom), $urandom, $urandom));
        end else if (j < 99) begin
          pending_q.push_back(mk_req(REQ_UNUSED, $urandom, $urandom, $urandom, $urandom,
                                     $urandom));
        end else begin
          pending_q.push_back(mk_req(REQ_CLEAR, $urandom, $urandom, $urandom, $urandom,
                                     $urandom));
        end
      end
    end
  end

  // Reset, then watchdog and end of run
  initial begin
    int drain;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    while (!(stim_done && expected_q.size() == 0)) begin
      @(posedge clk);
      if (idle_cycles >= STALL_LIMIT) begin
        $display("keyed_position_trail_store_unit: mismatch");
        $finish;
      end
    end
    drain = 0;
    while (drain < DRAIN_CYCLES) begin
      @(posedge clk);
      drain++;
    end
    if (errors == 0 && expected_q.size() == 0) begin
      $display("keyed_position_trail_store_unit: match");
    end else begin
      $display("keyed_position_trail_store_unit: mismatch");
    end
    $finish;
  end

  // Drive requests and config writes; config only once the block has drained
  always @(posedge clk) begin
    trail_req_t r;
    bit idle_now;
    if (!rst_n) begin
      pred_step = MIN_STEP_RST;
      for (int i = 0; i < ENTRIES; i++) pred_used[i] = 1'b0;
    end else begin
      // Count cycles with no beat on any channel
      if ((start && !busy) || (cfg_valid && cfg_ready) || out_strobe) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (start && !busy) begin
        r.req = in_req_type; r.key = in_aircraft_id; r.lat = in_lat_in;
        r.lon = in_lon_in; r.now = in_now_ms; r.pidx = in_point_index;
        expected_q.push_back(predict_trail(r));
        beat_no <= beat_no + 1;
      end
      if (cfg_valid && cfg_ready) begin
        pred_step = cfg_min_step;
      end
      // No idling in a middle stretch of beats
      idle_now = (beat_no < 300 || beat_no > 600) && ($urandom_range(99, 0) < 19);
      if (cfg_valid && !cfg_ready) begin
        // hold the write
      end else if (start && busy) begin
        // hold the beat
      end else if (pending_q.size() == 0) begin
        start <= 1'b0;
        cfg_valid <= 1'b0;
        if (!(start && !busy) && !(cfg_valid && cfg_ready)) stim_done <= 1'b1;
      end else if (pending_q[0].is_cfg) begin
        start <= 1'b0;
        cfg_valid <= 1'b0;
        if (expected_q.size() == 0 && !(start && !busy) && !cfg_valid) begin
          // let any trailing work settle before the write
          if (!cfg_wait) begin
            cfg_wait = 1'b1;
            repeat (DRAIN_CYCLES) @(posedge clk);
          end
          if (expected_q.size() == 0) begin
            r = pending_q.pop_front();
            cfg_min_step <= r.step;
            cfg_valid <= 1'b1;
            cfg_wait = 1'b0;
          end
        end
      end else if (idle_now) begin
        start <= 1'b0;
        cfg_valid <= 1'b0;
      end else begin
        r = pending_q.pop_front();
        in_req_type <= r.req;
        in_aircraft_id <= r.key;
        in_lat_in <= r.lat;
        in_lon_in <= r.lon;
        in_now_ms <= r.now;
        in_point_index <= r.pidx;
        start <= 1'b1;
        cfg_valid <= 1'b0;
      end
    end
  end

  // Check each strobed result against the oldest expectation
  always @(posedge clk) begin
    trail_resp_t want;
    if (rst_n && out_strobe) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result, status", out_status, -1);
      end else begin
        want = expected_q.pop_front();
        if (out_status !== want.status) report_mismatch("status", out_status, want.status);
        if (out_point_count !== want.count)
          report_mismatch("point_count", out_point_count, want.count);
        if (out_lat_out !== want.lat) report_mismatch("lat_out", out_lat_out, want.lat);
        if (out_lon_out !== want.lon) report_mismatch("lon_out", out_lon_out, want.lon);
      end
    end
  end

endmodule
